// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("assertion failed");

`endif

// ----- src/tskd_pkg.sv -----
`default_nettype none
package tskd_pkg;

	localparam int unsigned CAND_W  = 32;
	localparam int unsigned KEY_W   = 64;
	localparam int unsigned DIG_W   = 160;
	localparam int unsigned BLOCK_W = 512;
	localparam int unsigned ROUNDS  = 80;
	localparam int unsigned IDX_W   = 8;

	localparam logic [KEY_W-1:0] KEY_HIGH_RESET = 64'h7721_4D4B_196A_87CD;
	localparam logic [KEY_W-1:0] KEY_LOW_RESET  = 64'h5200_45FD_20A5_1D67;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_KEY_HIGH = 8'd0;
	localparam logic [IDX_W-1:0] REG_KEY_LOW  = 8'd1;

	// Message lengths in bits of the three hashes.
	localparam logic [63:0] LEN_A = 64'd160;
	localparam logic [63:0] LEN_B = 64'd320;
	localparam logic [63:0] LEN_D = 64'd256;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha1_state_t;

	// Sixteen-word schedule window; word 0 is the one used by the current round.
	typedef logic [15:0][31:0] sha1_win_t;

	localparam sha1_state_t H_INIT = '{
		a: 32'h6745_2301, b: 32'hEFCD_AB89, c: 32'h98BA_DCFE,
		d: 32'h1032_5476, e: 32'hC3D2_E1F0};

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	// One SHA-1 round; the round number is a constant at each use.
	function automatic sha1_state_t sha1_round(input sha1_state_t s, input logic [31:0] w,
		input int unsigned r);
		logic [31:0] f;
		logic [31:0] k;
		sha1_state_t n;
		if (r < 20) begin
			f = (s.b & s.c) | (~s.b & s.d);
			k = 32'h5A82_7999;
		end else if (r < 40) begin
			f = s.b ^ s.c ^ s.d;
			k = 32'h6ED9_EBA1;
		end else if (r < 60) begin
			f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
			k = 32'h8F1B_BCDC;
		end else begin
			f = s.b ^ s.c ^ s.d;
			k = 32'hCA62_C1D6;
		end
		n.a = rotl(s.a, 5) + f + s.e + k + w;
		n.b = s.a;
		n.c = rotl(s.b, 30);
		n.d = s.c;
		n.e = s.d;
		return n;
	endfunction

	// Slide the schedule window by one word, appending the next expanded word.
	function automatic sha1_win_t win_shift(input sha1_win_t w);
		sha1_win_t n;
		for (int j = 0; j < 15; j++) begin
			n[j] = w[j+1];
		end
		n[15] = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
		return n;
	endfunction

	function automatic sha1_win_t win_load(input logic [BLOCK_W-1:0] blk);
		sha1_win_t n;
		for (int j = 0; j < 16; j++) begin
			n[j] = blk[BLOCK_W-1-32*j -: 32];
		end
		return n;
	endfunction

	function automatic logic [DIG_W-1:0] sha1_final(input sha1_state_t s);
		sha1_final = {s.a + H_INIT.a, s.b + H_INIT.b, s.c + H_INIT.c,
			s.d + H_INIT.d, s.e + H_INIT.e};
	endfunction

	// Candidate bytes, least significant first, as a big-endian word.
	function automatic logic [CAND_W-1:0] cand_bytes(input logic [CAND_W-1:0] c);
		cand_bytes = {c[7:0], c[15:8], c[23:16], c[31:24]};
	endfunction

endpackage
`default_nettype wire

// ----- src/tskd_if.sv -----
`default_nettype none
interface tskd_in_if;
	import tskd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CAND_W-1:0] candidate;
	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface tskd_out_if;
	import tskd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CAND_W-1:0] candidate_echo;
	logic [63:0]       digest_first;
	logic [63:0]       digest_middle;
	logic [31:0]       digest_last;
	modport source (output valid, output candidate_echo, output digest_first,
		output digest_middle, output digest_last, input ready);
	modport sink (input valid, input candidate_echo, input digest_first,
		input digest_middle, input digest_last, output ready);
endinterface
`default_nettype wire

// ----- src/triple_sha1_key_derivation.sv -----
// An accepted word passes three times 80 round stages and an output register.
// Throughput: one word per cycle while the output does not stall; each SHA-1
// round has its own pipeline stage, and a stall on the output holds the whole
// pipeline and drops input ready.
// Reset clears the valid bits and loads the key registers with the fixed key.
`default_nettype none
module triple_sha1_key_derivation (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tskd_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [tskd_pkg::KEY_W-1:0]  cfg_wdata,
	tskd_in_if.sink                          req,
	tskd_out_if.source                       rsp
);
	import tskd_pkg::*;

	localparam int unsigned SIDE2_W = CAND_W + DIG_W;

	logic [KEY_W-1:0] key_high_q;
	logic [KEY_W-1:0] key_low_q;
	logic             en;

	logic [DIG_W-1:0]   dig_a, dig_b, dig_d;
	logic [CAND_W-1:0]  cand_a, cand_d;
	logic [SIDE2_W-1:0] side_b;
	logic               vld_a, vld_b, vld_d;
	logic [BLOCK_W-1:0] blk_a, blk_b, blk_d;

	logic              out_vld_q;
	logic [CAND_W-1:0] out_cand_q;
	logic [DIG_W-1:0]  out_dig_q;

	// Key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= KEY_HIGH_RESET;
			key_low_q  <= KEY_LOW_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_wdata;
			end
			if (cfg_index == REG_KEY_LOW) begin
				key_low_q <= cfg_wdata;
			end
		end
	end

	// The pipeline advances whenever the output register is free or being taken.
	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;

	// First hash: key and candidate, 20 bytes.
	assign blk_a = {key_high_q, key_low_q, cand_bytes(req.candidate), 8'h80,
		{(BLOCK_W-KEY_W*2-CAND_W-8-64){1'b0}}, LEN_A};

	tskd_sha1_pipe #(.SIDE_W(CAND_W)) u_hash_a (
		.clk, .arst_n, .en,
		.in_valid  (req.valid),
		.in_block  (blk_a),
		.in_side   (req.candidate),
		.out_valid (vld_a),
		.out_digest(dig_a),
		.out_side  (cand_a)
	);

	// Second hash: key, first digest and candidate, 40 bytes.
	assign blk_b = {key_high_q, key_low_q, dig_a, cand_bytes(cand_a), 8'h80,
		{(BLOCK_W-KEY_W*2-DIG_W-CAND_W-8-64){1'b0}}, LEN_B};

	tskd_sha1_pipe #(.SIDE_W(SIDE2_W)) u_hash_b (
		.clk, .arst_n, .en,
		.in_valid  (vld_a),
		.in_block  (blk_b),
		.in_side   ({cand_a, dig_a}),
		.out_valid (vld_b),
		.out_digest(dig_b),
		.out_side  (side_b)
	);

	// Third hash: first 16 bytes of each earlier digest.
	assign blk_d = {side_b[DIG_W-1 -: 128], dig_b[DIG_W-1 -: 128], 8'h80,
		{(BLOCK_W-256-8-64){1'b0}}, LEN_D};

	tskd_sha1_pipe #(.SIDE_W(CAND_W)) u_hash_d (
		.clk, .arst_n, .en,
		.in_valid  (vld_b),
		.in_block  (blk_d),
		.in_side   (side_b[SIDE2_W-1 -: CAND_W]),
		.out_valid (vld_d),
		.out_digest(dig_d),
		.out_side  (cand_d)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_cand_q <= cand_d;
			out_dig_q  <= dig_d;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.candidate_echo = out_cand_q;
	assign rsp.digest_first   = out_dig_q[159:96];
	assign rsp.digest_middle  = out_dig_q[95:32];
	assign rsp.digest_last    = out_dig_q[31:0];
endmodule
`default_nettype wire

// ----- src/tskd_sha1_pipe.sv -----
`default_nettype none
module tskd_sha1_pipe #(
	parameter int unsigned SIDE_W = tskd_pkg::CAND_W
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [tskd_pkg::BLOCK_W-1:0] in_block,
	input  wire logic [SIDE_W-1:0]            in_side,
	output logic                              out_valid,
	output logic [tskd_pkg::DIG_W-1:0]        out_digest,
	output logic [SIDE_W-1:0]                 out_side
);
	import tskd_pkg::*;

	logic        vld_s  [ROUNDS];
	sha1_state_t st_s   [ROUNDS];
	sha1_win_t   win_s  [ROUNDS];
	logic [SIDE_W-1:0] side_s [ROUNDS];

	// One round per stage; the whole chain moves together on enable.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		logic              vld_i;
		sha1_state_t       st_i;
		sha1_win_t         win_i;
		logic [SIDE_W-1:0] side_i;

		if (r == 0) begin : g_first
			assign vld_i  = in_valid;
			assign st_i   = H_INIT;
			assign win_i  = win_load(in_block);
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[r-1];
			assign st_i   = st_s[r-1];
			assign win_i  = win_s[r-1];
			assign side_i = side_s[r-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r] <= 1'b0;
			end else if (en) begin
				vld_s[r] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[r]   <= sha1_round(st_i, win_i[0], r);
				win_s[r]  <= win_shift(win_i);
				side_s[r] <= side_i;
			end
		end
	end

	// Feed-forward addition of the initial chaining value.
	assign out_valid  = vld_s[ROUNDS-1];
	assign out_digest = sha1_final(st_s[ROUNDS-1]);
	assign out_side   = side_s[ROUNDS-1];
endmodule
`default_nettype wire

// ----- src/tskd_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module tskd_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_candidate_echo,
	input wire logic [63:0] rsp_digest_first
);
	// A result held back by the sink stays offered.
	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	// Input is taken exactly when the output register can move.
	`ASSERT_ALWAYS(a_ready_link, req_ready == (!rsp_valid || rsp_ready))
	// A result held back by the sink keeps its candidate echo and first digest word.
	`ASSERT_NEXT(a_stall_blocks, rsp_valid && !rsp_ready,
		$stable(rsp_candidate_echo) && $stable(rsp_digest_first))
	// An offered result never carries unknown bits in its candidate echo or first digest word.
	`ASSERT_ALWAYS(a_known, !rsp_valid || !$isunknown({rsp_candidate_echo, rsp_digest_first}))
endmodule

bind triple_sha1_key_derivation tskd_props u_tskd_props (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_candidate_echo(rsp.candidate_echo),
	.rsp_digest_first  (rsp.digest_first)
);
`default_nettype wire

// ----- test/tskd_checker.sv -----
`default_nettype none
module tskd_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tskd_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [tskd_pkg::KEY_W-1:0]  cfg_wdata,
	tskd_in_if                               req,
	tskd_out_if                              rsp,
	output int                               fail_count,
	output int                               outstanding,
	output int                               digests_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import tskd_pkg::*;

	typedef struct {
		logic [31:0] cand;
		logic [63:0] first;
		logic [63:0] middle;
		logic [31:0] last;
	} digest_rec_t;

	digest_rec_t digest_q[$];
	logic [63:0] key_hi;
	logic [63:0] key_lo;

	// Compression of one padded block from the standard initial values.
	function automatic logic [159:0] sha1_compress(input logic [511:0] blk);
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		a = 32'h67452301; b = 32'hEFCDAB89; c = 32'h98BADCFE;
		d = 32'h10325476; e = 32'hC3D2E1F0;
		for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
		for (int i = 16; i < 80; i++) begin
			x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {x[30:0], x[31]};
		end
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
		end
		return {a + 32'h67452301, b + 32'hEFCDAB89, c + 32'h98BADCFE,
			d + 32'h10325476, e + 32'hC3D2E1F0};
	endfunction

	// Hash of a short message held left-aligned in msg, nbits long.
	function automatic logic [159:0] sha1_short(input logic [319:0] msg, input int nbits);
		logic [511:0] blk;
		blk = '0;
		blk[511 -: 320] = msg;
		blk[511-nbits -: 8] = 8'h80;
		blk[63:0] = 64'(nbits);
		return sha1_compress(blk);
	endfunction

	function automatic digest_rec_t derive_digest(input logic [31:0] cand);
		digest_rec_t r;
		logic [31:0] c4;
		logic [159:0] ha, hb, hd;
		c4 = {cand[7:0], cand[15:8], cand[23:16], cand[31:24]};
		ha = sha1_short({key_hi, key_lo, c4, 160'd0}, 160);
		hb = sha1_short({key_hi, key_lo, ha, c4}, 320);
		hd = sha1_short({ha[159:32], hb[159:32], 64'd0}, 256);
		r.cand = cand;
		r.first = hd[159:96];
		r.middle = hd[95:32];
		r.last = hd[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		digests_seen = 0;
	end

	assign outstanding = digest_q.size();

	// Key registers follow the configuration port; other indexes are ignored.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi <= KEY_HIGH_RESET;
			key_lo <= KEY_LOW_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_HIGH) key_hi <= cfg_wdata;
			else if (cfg_index == REG_KEY_LOW) key_lo <= cfg_wdata;
		end
	end

	// Predict on every accepted input word and compare every accepted result word.
	always @(posedge clk) begin
		digest_rec_t want;
		if (arst_n) begin
			if (req.valid && req.ready) digest_q.push_back(derive_digest(req.candidate));
			if (rsp.valid && rsp.ready) begin
				digests_seen++;
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected word", 64'(rsp.candidate_echo), 64'd0);
				end else begin
					want = digest_q.pop_front();
					if (rsp.candidate_echo !== want.cand)
						report_mismatch("candidate_echo", 64'(rsp.candidate_echo),
							64'(want.cand));
					if (rsp.digest_first !== want.first)
						report_mismatch("digest_first", rsp.digest_first, want.first);
					if (rsp.digest_middle !== want.middle)
						report_mismatch("digest_middle", rsp.digest_middle, want.middle);
					if (rsp.digest_last !== want.last)
						report_mismatch("digest_last", 64'(rsp.digest_last), 64'(want.last));
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- test/tb_triple_sha1_key_derivation.sv -----
`default_nettype none
module tb_triple_sha1_key_derivation;
	timeunit 1ns;
	timeprecision 1ps;
	import tskd_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0] cfg_wdata = '0;
	logic             quiet = 1'b1;
	int               fail_count;
	int               outstanding;
	int               digests_seen;
	int               cycles = 0;
	int               sent = 0;
	int               key_writes = 0;

	tskd_in_if  req ();
	tskd_out_if rsp ();

	triple_sha1_key_derivation uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
	);

	tskd_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req), .rsp(rsp), .fail_count(fail_count),
		.outstanding(outstanding), .digests_seen(digests_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.candidate = '0;
		rsp.ready = 1'b0;
	end

	// Run limit, far beyond the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	// Result side: stalls at random between accepted words.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			gap = draw_gap();
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(negedge clk);
			while (!rsp.valid) @(negedge clk);
		end
	end

	// Send one candidate word, after a random gap.
	task automatic send_candidate(input logic [31:0] cand);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.candidate <= cand;
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	// Drain the pipeline, then write one register while the block is idle.
	task automatic write_key(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
		req.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (260) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		key_writes++;
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
			send_candidate($urandom());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with the reset key: extremes and walking bits.
		quiet = 1'b1;
		send_candidate(32'h0000_0000);
		send_candidate(32'hFFFF_FFFF);
		send_candidate(32'h0000_0001);
		send_candidate(32'h8000_0000);
		send_candidate(32'h0102_0304);
		send_candidate(32'h5555_5555);
		send_candidate(32'hAAAA_AAAA);
		for (int b = 0; b < 32; b += 4) send_candidate(32'h1 << b);
		quiet = 1'b0;
		for (int i = 0; i < 6; i++) send_candidate($urandom());
		random_phase(300);

		// All-zero key, then two out-of-range indexes that must change nothing.
		write_key(REG_KEY_HIGH, '0);
		write_key(REG_KEY_LOW, '0);
		send_candidate(32'h0000_0000);
		send_candidate(32'hFFFF_FFFF);
		write_key(REG_KEY_LOW + 8'd1, '1);
		write_key(8'hFF, 64'h0123_4567_89AB_CDEF);
		random_phase(300);

		// All-ones key.
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		send_candidate(32'h0000_0000);
		send_candidate(32'hFFFF_FFFF);
		random_phase(300);

		// Random keys.
		for (int p = 0; p < 2; p++) begin
			write_key(REG_KEY_HIGH, {$urandom(), $urandom()});
			write_key(REG_KEY_LOW, {$urandom(), $urandom()});
			random_phase(150);
		end

		// Back to the reset key.
		write_key(REG_KEY_HIGH, KEY_HIGH_RESET);
		write_key(REG_KEY_LOW, KEY_LOW_RESET);
		random_phase(300);
		req.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d candidates, checked %0d digests across %0d key register writes.",
			sent, digests_seen, key_writes);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
